/* rtl/kvt_pkg.sv */
// Shared constants, request types and operation codes of the key-value table.
package kvt_pkg;

	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;
	localparam int IDX_W      = $clog2(ENTRIES);

	localparam int OP_W       = 3;
	localparam int KEY_W      = 32;
	localparam int VALUE_W    = 32;

	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
	localparam logic [OP_W-1:0] OP_LOOKUP   = 3'd1;
	localparam logic [OP_W-1:0] OP_CONTAINS = 3'd2;
	localparam logic [OP_W-1:0] OP_ERASE    = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;

	typedef logic [KEY_BITS-1:0]   key_t;
	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [IDX_W-1:0]      idx_t;

	// Classified request, as the back end carries it out.
	typedef struct packed {
		logic   add;          // insert or lookup: may add the key
		logic   wr_value;     // insert: overwrite value on a hit
		logic   rd_value;     // lookup: return value on a hit
		logic   erase;
		logic   clear;
		key_t   key;
		value_t store_value;  // value written when the key is added or an insert hits
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} st_t;

endpackage

/* rtl/kvt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module kvt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/kvt_front.sv */
// Front end: accepts requests, decodes the operation and queues them for the back end.
module kvt_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  logic [kvt_pkg::OP_W-1:0]    operation,
	input  logic [kvt_pkg::KEY_W-1:0]   key,
	input  logic [kvt_pkg::VALUE_W-1:0] value,
	output logic                  q_valid,
	output kvt_pkg::req_t         q_req,
	input  logic                  q_pop
);
	import kvt_pkg::*;

	req_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	req_t              dec;
	logic              push;
	logic              pop;

	always_comb begin
		dec             = '0;
		dec.key         = KEY_BITS'(key);
		dec.add         = (operation == OP_INSERT) || (operation == OP_LOOKUP);
		dec.wr_value    = (operation == OP_INSERT);
		dec.rd_value    = (operation == OP_LOOKUP);
		dec.erase       = (operation == OP_ERASE);
		dec.clear       = (operation == OP_CLEAR);
		// lookup adds a missing key with a zero value
		dec.store_value = (operation == OP_INSERT) ? VALUE_BITS'(value) : '0;
	end

	assign req_ready = (cnt_q != QCNT_W'(QDEPTH));
	assign push      = req_valid && req_ready;
	assign q_valid   = (cnt_q != '0);
	assign pop       = q_pop && q_valid;
	assign q_req     = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* rtl/kvt_back.sv */
// Back end: scans the table one entry a cycle, then commits the update and the response.
module kvt_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  kvt_pkg::req_t         q_req,
	output logic                  q_pop,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output logic                  found,
	output logic [kvt_pkg::VALUE_W-1:0] read_value,
	output logic                  status
);
	import kvt_pkg::*;

	st_t               st_q;
	st_t               st_d;
	req_t              req_q;
	idx_t              idx_q;
	logic              cmp_vld_s1;
	idx_t              cmp_idx_s1;
	logic              hit_q;
	idx_t              hit_idx_q;
	value_t            hit_val_q;
	logic              free_q;
	idx_t              free_idx_q;
	logic [ENTRIES-1:0] valid_q;
	logic              out_vld_q;
	logic              out_found_q;
	value_t            out_val_q;
	logic              out_status_q;

	key_t              key_rdata;
	value_t            val_rdata;
	logic              out_free;
	logic              commit;
	logic              add_new;
	logic              key_we;
	logic              val_we;
	idx_t              val_waddr;
	logic              scan_last;

	assign out_free  = !out_vld_q || rsp_ready;
	assign scan_last = (idx_q == IDX_W'(ENTRIES - 1));
	assign add_new   = req_q.add && !hit_q && free_q;

	kvt_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (free_idx_q),
		.wdata (req_q.key),
		.raddr (idx_q),
		.rdata (key_rdata)
	);

	kvt_ram #(.WIDTH(VALUE_BITS), .DEPTH(ENTRIES)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (req_q.store_value),
		.raddr (idx_q),
		.rdata (val_rdata)
	);

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE:   if (q_valid) st_d = ST_SCAN;
			ST_SCAN:   if (scan_last) st_d = ST_DRAIN;
			ST_DRAIN:  st_d = ST_COMMIT;
			ST_COMMIT: if (out_free) st_d = ST_IDLE;
			default:   st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		commit    = 1'b0;
		key_we    = 1'b0;
		val_we    = 1'b0;
		val_waddr = hit_q ? hit_idx_q : free_idx_q;
		case (st_q)
			ST_IDLE:   q_pop = q_valid;
			ST_COMMIT: begin
				commit = out_free;
				key_we = out_free && add_new;
				val_we = out_free && (add_new || (req_q.wr_value && hit_q));
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	// request and scan payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			req_q <= q_req;
		end
		cmp_idx_s1 <= idx_q;
		if (cmp_vld_s1 && valid_q[cmp_idx_s1] && (key_rdata == req_q.key)) begin
			hit_idx_q <= cmp_idx_s1;
			hit_val_q <= val_rdata;
		end
		if (cmp_vld_s1 && !valid_q[cmp_idx_s1] && !free_q) begin
			free_idx_q <= cmp_idx_s1;
		end
		if (commit) begin
			out_found_q  <= hit_q;
			out_val_q    <= (req_q.rd_value && hit_q) ? hit_val_q : '0;
			out_status_q <= req_q.add && !hit_q && !free_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			idx_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			valid_q    <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			st_q       <= st_d;
			cmp_vld_s1 <= (st_q == ST_SCAN);
			if (st_q == ST_SCAN) begin
				idx_q <= scan_last ? '0 : idx_q + 1'b1;
			end
			if (q_pop) begin
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else if (cmp_vld_s1) begin
				if (valid_q[cmp_idx_s1] && (key_rdata == req_q.key)) begin
					hit_q <= 1'b1;
				end
				if (!valid_q[cmp_idx_s1]) begin
					free_q <= 1'b1;
				end
			end
			if (commit) begin
				if (req_q.clear) begin
					valid_q <= '0;
				end else if (req_q.erase && hit_q) begin
					valid_q[hit_idx_q] <= 1'b0;
				end else if (add_new) begin
					valid_q[free_idx_q] <= 1'b1;
				end
			end
			// hold the response until taken
			if (commit) begin
				out_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign rsp_valid  = out_vld_q;
	assign found      = out_found_q;
	assign read_value = VALUE_W'(out_val_q);
	assign status     = out_status_q;

endmodule

/* rtl/linear_key_value_table.sv */
// Linear key-value table: fixed-capacity associative array searched one entry a cycle.
// Requests are carried out one at a time: the back end scans every entry for one request
// and commits it before it takes the next one from the queue.
// A two-entry request queue lets requests be accepted while the scan runs.
// Reset empties the table at once (entry valid flops); key and value RAMs are not cleared.
// Response register holds a finished result while the next request is scanned.
module linear_key_value_table (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  logic [kvt_pkg::OP_W-1:0]    operation,
	input  logic [kvt_pkg::KEY_W-1:0]   key,
	input  logic [kvt_pkg::VALUE_W-1:0] value,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output logic                  found,
	output logic [kvt_pkg::VALUE_W-1:0] read_value,
	output logic                  status
);
	import kvt_pkg::*;

	logic q_valid;
	req_t q_req;
	logic q_pop;

	kvt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.operation (operation),
		.key       (key),
		.value     (value),
		.q_valid   (q_valid),
		.q_req     (q_req),
		.q_pop     (q_pop)
	);

	kvt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_req      (q_req),
		.q_pop      (q_pop),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.found      (found),
		.read_value (read_value),
		.status     (status)
	);

endmodule
